// File: hdl/psr_pkg.sv
package psr_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned SumW     = 24;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned WidthW   = 13;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgDataW = 13;

  // Gamma stage: the radicand never exceeds 255*255, so the root fits in a channel.
  localparam int unsigned RadW  = 16;
  localparam int unsigned RootW = ChanW;
  localparam logic [RadW-1:0] GammaScale  = 16'd65025;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;

  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = SumW / DivBitsPerStage;
  localparam int unsigned SqrtBitsPerStage = 2;
  localparam int unsigned SqrtStages      = RootW / SqrtBitsPerStage;
  localparam int unsigned ChanLatency     = DivStages + 1 + SqrtStages;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    CfgSampleCount = 1'b0,
    CfgImageWidth  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [SumW-1:0]   sum_red;
    logic [SumW-1:0]   sum_green;
    logic [SumW-1:0]   sum_blue;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic [SampleW-1:0] rem;
    logic [SumW-1:0]    num;
  } div_state_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RootW:0]   rem;
    logic [RootW-1:0] root;
  } sqrt_state_t;

  // One restoring division step: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same word.
  function automatic div_state_t div_step(div_state_t s, logic [SampleW-1:0] d);
    logic [SampleW:0] trial;
    div_state_t       r;
    trial = {s.rem, s.num[SumW-1]};
    r.num = {s.num[SumW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      trial    = trial - {1'b0, d};
      r.num[0] = 1'b1;
    end
    r.rem = trial[SampleW-1:0];
    return r;
  endfunction

  // One digit of a binary square root; the remainder stays at most twice the root.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    logic [RootW+2:0] acc;
    logic [RootW+2:0] test;
    sqrt_state_t      r;
    acc    = {s.rem, s.rad[RadW-1 -: 2]};
    test   = {1'b0, s.root, 2'b01};
    r.rad  = {s.rad[RadW-3:0], 2'b00};
    r.root = {s.root[RootW-2:0], 1'b0};
    if (acc >= test) begin
      acc       = acc - test;
      r.root[0] = 1'b1;
    end
    r.rem = acc[RootW:0];
    return r;
  endfunction

endpackage

// File: hdl/psr_front.sv
module psr_front
  import psr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [WidthW-1:0]   stride_i,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [CoordW-1:0]   pixel_x_i,
  input  logic [CoordW-1:0]   pixel_y_i,
  input  logic [SumW-1:0]     sum_red_i,
  input  logic [SumW-1:0]     sum_green_i,
  input  logic [SumW-1:0]     sum_blue_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output item_t               item_o
);

  logic                     valid_q;
  item_t                    item_q;
  logic                     advance;
  logic [CoordW+WidthW-1:0] row_base;
  item_t                    item_d;

  assign advance   = !valid_q || !queue_full_i;
  assign s_ready_o = advance;
  assign push_o    = valid_q && !queue_full_i;
  assign item_o    = item_q;

  always_comb begin
    row_base         = pixel_y_i * stride_i;
    item_d.index     = IndexW'(row_base + (CoordW + WidthW)'(pixel_x_i));
    item_d.sum_red   = sum_red_i;
    item_d.sum_green = sum_green_i;
    item_d.sum_blue  = sum_blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// File: hdl/psr_queue.sv
module psr_queue
  import psr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  item_t         item_i,
  input  logic          pop_i,
  output item_t         item_o,
  output queue_status_t status_o
);

  item_t                entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/psr_chan.sv
module psr_chan
  import psr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SampleW-1:0] divisor_i,
  input  logic [SumW-1:0]    sum_i,
  output logic [ChanW-1:0]   chan_o
);

  localparam int unsigned MeanW = FRAC_BITS + 1;
  localparam int unsigned ProdW = MeanW + RadW;
  localparam logic [SumW:0] OneWide = {{SumW{1'b0}}, 1'b1} << FRAC_BITS;

  div_state_t  div_d [DivStages];
  div_state_t  div_q [DivStages];
  sqrt_state_t sq_d  [SqrtStages];
  sqrt_state_t sq_q  [SqrtStages];

  logic [SumW-1:0]  quot;
  logic [MeanW-1:0] mean;
  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] prod_q;
  logic [RadW-1:0]  radicand;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    always_comb begin
      div_state_t st;
      if (s == 0) begin
        st.rem = '0;
        st.num = sum_i;
      end else begin
        st = div_q[(s == 0) ? 0 : s - 1];
      end
      for (int b = 0; b < DivBitsPerStage; b++) begin
        st = div_step(st, divisor_i);
      end
      div_d[s] = st;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[s] <= div_d[s];
      end
    end
  end

  // The mean saturates at 1.0 before the 255^2 scaling.
  always_comb begin
    quot = div_q[DivStages-1].num;
    if ({1'b0, quot} > OneWide) begin
      mean = OneWide[MeanW-1:0];
    end else begin
      mean = MeanW'({1'b0, quot});
    end
    prod_d = ProdW'(mean) * ProdW'(GammaScale);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Dropping the fraction bits here leaves the root unchanged, since the
  // squared trial value has no fraction.
  assign radicand = RadW'(prod_q >> FRAC_BITS);

  for (genvar s = 0; s < SqrtStages; s++) begin : g_sqrt
    always_comb begin
      sqrt_state_t st;
      if (s == 0) begin
        st.rad  = radicand;
        st.rem  = '0;
        st.root = '0;
      end else begin
        st = sq_q[(s == 0) ? 0 : s - 1];
      end
      for (int b = 0; b < SqrtBitsPerStage; b++) begin
        st = sqrt_step(st);
      end
      sq_d[s] = st;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[s] <= sq_d[s];
      end
    end
  end

  assign chan_o = sq_q[SqrtStages-1].root;

endmodule

// File: hdl/psr_back.sv
module psr_back
  import psr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SampleW-1:0] divisor_i,
  input  item_t              item_i,
  input  logic               item_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IndexW-1:0]  pixel_index_o,
  output logic [ColorW-1:0]  packed_color_o
);

  logic              valid_q [ChanLatency];
  logic [IndexW-1:0] index_q [ChanLatency];
  logic              out_valid_q;
  logic [IndexW-1:0] out_index_q;
  logic [ColorW-1:0] out_color_q;
  logic              advance;
  logic [ChanW-1:0]  red;
  logic [ChanW-1:0]  green;
  logic [ChanW-1:0]  blue;

  // The whole pipeline moves as one; it halts only while a result is refused.
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && item_valid_i;

  psr_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
    .clk_i     (clk_i),
    .en_i      (advance),
    .divisor_i (divisor_i),
    .sum_i     (item_i.sum_red),
    .chan_o    (red)
  );

  psr_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
    .clk_i     (clk_i),
    .en_i      (advance),
    .divisor_i (divisor_i),
    .sum_i     (item_i.sum_green),
    .chan_o    (green)
  );

  psr_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
    .clk_i     (clk_i),
    .en_i      (advance),
    .divisor_i (divisor_i),
    .sum_i     (item_i.sum_blue),
    .chan_o    (blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ChanLatency; s++) begin
        valid_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= item_valid_i;
      for (int s = 1; s < ChanLatency; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
      out_valid_q <= valid_q[ChanLatency-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      index_q[0] <= item_i.index;
      for (int s = 1; s < ChanLatency; s++) begin
        index_q[s] <= index_q[s-1];
      end
      out_index_q <= index_q[ChanLatency-1];
      out_color_q <= {AlphaOpaque, red, green, blue};
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_index_o  = out_index_q;
  assign packed_color_o = out_color_q;

endmodule

// File: hdl/pixel_sample_resolve_pack_core.sv
// Channel   Direction  Payload
// s_axis    in         tdata: pixel_x, pixel_y, sum_red, sum_green, sum_blue
// m_axis    out        tdata: pixel_index, packed_color
// cfg       in         register write: sample_count (0), image_width (1)
//
// While the queue has room one pixel is taken every cycle; the rate is set
// by the fully pipelined divider (two quotient bits per stage) and root (two
// bits per stage) units; each result leaves through a registered output.
// Reset clears all valid flags; the registers return to 1 and 640.
// A refused result halts the back pipeline only; the front keeps accepting
// until the four-entry queue between them fills.
module pixel_sample_resolve_pack_core
  import psr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_x [11:0], pixel_y [23:12], sum_red [47:24], sum_green [71:48], sum_blue [95:72]
  input  logic [95:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_index [23:0], packed_color [55:24]
  output logic [55:0]           m_axis_tdata
);

  localparam int unsigned CmpW = WidthW + 2;
  localparam logic [CmpW-1:0] MaxWidthL = CmpW'(MAX_WIDTH);

  logic [SampleW-1:0] sample_count_q;
  logic [WidthW-1:0]  image_width_q;
  logic [SampleW-1:0] divisor;
  logic [WidthW-1:0]  stride;
  logic               push;
  logic               pop;
  item_t              front_item;
  item_t              head_item;
  queue_status_t      q_stat;
  logic [IndexW-1:0]  pixel_index;
  logic [ColorW-1:0]  packed_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SampleW'(1);
      image_width_q  <= WidthW'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgSampleCount: sample_count_q <= cfg_wdata_i[SampleW-1:0];
        CfgImageWidth:  image_width_q  <= cfg_wdata_i[WidthW-1:0];
        default:        ;
      endcase
    end
  end

  // A zero count divides as one; a width beyond the maximum uses the maximum.
  assign divisor = (sample_count_q == '0) ? SampleW'(1) : sample_count_q;
  assign stride  = ({2'b00, image_width_q} > MaxWidthL) ? WidthW'(MaxWidthL)
                                                        : image_width_q;

  psr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stride_i     (stride),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .pixel_x_i    (s_axis_tdata[11:0]),
    .pixel_y_i    (s_axis_tdata[23:12]),
    .sum_red_i    (s_axis_tdata[47:24]),
    .sum_green_i  (s_axis_tdata[71:48]),
    .sum_blue_i   (s_axis_tdata[95:72]),
    .queue_full_i (q_stat.full),
    .push_o       (push),
    .item_o       (front_item)
  );

  psr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_stat)
  );

  psr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .divisor_i      (divisor),
    .item_i         (head_item),
    .item_valid_i   (!q_stat.empty),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_index_o  (pixel_index),
    .packed_color_o (packed_color)
  );

  assign m_axis_tdata = {packed_color, pixel_index};

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QueueCntW'(QueueDepth))
    else $error("request queue count beyond its depth");

  a_ready_low_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("input refused while the queue has room");

  a_full_holds_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full && !pop |=> q_stat.full)
    else $error("queue lost an entry without a pop");

  a_alpha_opaque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:48] == AlphaOpaque)
    else $error("result alpha is not opaque");

endmodule
